FILE: src/shortest_path_with_cost_tiebreak_assert.svh
// Assertion macros for the shortest path block.
`ifndef SHORTEST_PATH_WITH_COST_TIEBREAK_ASSERT_SVH
`define SHORTEST_PATH_WITH_COST_TIEBREAK_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SPT_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SPT_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/spt_pkg.sv
// Shared constants for the shortest path block.
`default_nettype none
package spt_pkg;
    localparam int NODE_FIELD_W = 6;
    localparam int EDGE_FIELD_W = 16;
    localparam int CMD_W        = 2;
    localparam int CFG_W        = 7;
    localparam int RES_W        = 22;
    localparam int IN_DATA_W    = 56;
    localparam int OUT_DATA_W   = 48;

    localparam logic [CFG_W-1:0] NODE_COUNT_RESET = 7'd64;
    localparam logic [RES_W-1:0] RES_MAX          = 22'h3FFFFF;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;
endpackage
`default_nettype wire

FILE: src/shortest_path_with_cost_tiebreak.sv
// Top level: command decode, edge store, search control and the row of node cells.
//
// Input stream s_*: s_tuser carries the command (clear, add edge, query), s_tdata the
// edge and query fields. Output stream m_*: one result per query, none for clear or add.
// Configuration: cfg_wr_en/cfg_wr_data write node_count; write it only while idle.
//
// Operation, with N = MAX_NODES:
//   reset: a clearing pass over all N*N entries empties the edge store; s_tready stays low.
//   clear: the same clearing pass.  add edge: one store write per direction.
//   query: one pass per settled node plus one; in each pass the search token
//   walks the N cells while one edge store row is read a column per cycle.
//   An out-of-range query goes straight to its result without a search.
// The result sits in an output register: a stalled receiver holds it there while the
// block takes the next request; a second query result waits until the first is taken.
`default_nettype none
module shortest_path_with_cost_tiebreak #(
    parameter int MAX_NODES   = 64,
    parameter int WEIGHT_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [5:0] edge_from, [11:6] edge_to, [27:12] edge_length, [43:28] edge_price,
    // [49:44] source_node, [55:50] dest_node
    input  wire logic [spt_pkg::IN_DATA_W-1:0] s_tdata,
    // [1:0] cmd
    input  wire logic [spt_pkg::CMD_W-1:0]     s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [0] reachable, [22:1] path_length, [44:23] path_price, [47:45] zero
    output logic [spt_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  wire logic                          cfg_wr_en,
    input  wire logic [spt_pkg::CFG_W-1:0]     cfg_wr_data
);
    import spt_pkg::*;
    `include "shortest_path_with_cost_tiebreak_assert.svh"

    localparam int NW  = $clog2(MAX_NODES);
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int LW  = WEIGHT_BITS + NW;
    localparam int AW  = $clog2(MAX_NODES * MAX_NODES);
    localparam int MW  = 1 + 2 * WEIGHT_BITS;

    typedef struct packed {
        logic                   present;
        logic [WEIGHT_BITS-1:0] len;
        logic [WEIGHT_BITS-1:0] price;
    } edge_t;

    typedef struct packed {
        logic          valid;
        logic          init;
        logic [NW-1:0] settle_idx;
        logic [NW-1:0] src_idx;
        logic [NW-1:0] dst_idx;
        logic [LW-1:0] base_len;
        logic [LW-1:0] base_price;
        logic          found;
        logic [NW-1:0] min_idx;
        logic [LW-1:0] min_len;
        logic [LW-1:0] min_price;
        logic          dst_fin;
        logic [LW-1:0] dst_len;
        logic [LW-1:0] dst_price;
    } pkt_t;

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_ADD_A = 7'b0000100,
        ST_ADD_B = 7'b0001000,
        ST_ISSUE = 7'b0010000,
        ST_WAIT  = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0] node_count_reg;
    logic [NCW-1:0]   node_lim;

    logic [AW-1:0] clr_reg, clr_next;
    logic [NW-1:0] col_reg, col_next;
    logic [NW-1:0] row_reg, row_next;
    logic          inject_reg;
    logic          init_reg, init_next;
    logic [LW-1:0] base_len_reg, base_len_next;
    logic [LW-1:0] base_price_reg, base_price_next;
    logic [NW-1:0] src_reg, src_next;
    logic [NW-1:0] dst_reg, dst_next;

    logic [AW-1:0]          addr_a_reg, addr_a_next;
    logic [AW-1:0]          addr_b_reg, addr_b_next;
    logic [WEIGHT_BITS-1:0] wlen_reg, wlen_next;
    logic [WEIGHT_BITS-1:0] wprice_reg, wprice_next;

    logic             res_fin_reg, res_fin_next;
    logic [RES_W-1:0] res_len_reg, res_len_next;
    logic [RES_W-1:0] res_price_reg, res_price_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [MW-1:0] mem [MAX_NODES*MAX_NODES];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [MW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    edge_t         rd_data_reg;

    pkt_t chain [MAX_NODES+1];
    pkt_t head_pkt;
    pkt_t exit_pkt;

    logic                    accept;
    logic [NODE_FIELD_W-1:0] in_from, in_to, in_src, in_dst;
    logic                    add_bad, query_bad;

    function automatic logic [RES_W-1:0] sat_res(input logic [LW-1:0] v);
        logic [63:0] wide;
        wide = 64'(v);
        if (wide > 64'(RES_MAX))
        begin
            return RES_MAX;
        end
        return wide[RES_W-1:0];
    endfunction

    assign in_from = s_tdata[5:0];
    assign in_to   = s_tdata[11:6];
    assign in_src  = s_tdata[49:44];
    assign in_dst  = s_tdata[55:50];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        if (node_count_reg == '0)
        begin
            node_lim = NCW'(1);
        end
        else if (32'(node_count_reg) > MAX_NODES)
        begin
            node_lim = NCW'(MAX_NODES);
        end
        else
        begin
            node_lim = NCW'(node_count_reg);
        end
    end

    assign add_bad   = (in_from == in_to) || (32'(in_from) >= MAX_NODES) ||
                       (32'(in_to) >= MAX_NODES);
    assign query_bad = (32'(in_src) >= 32'(node_lim)) || (32'(in_dst) >= 32'(node_lim));

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        init_next       = init_reg;
        base_len_next   = base_len_reg;
        base_price_next = base_price_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        addr_a_next     = addr_a_reg;
        addr_b_next     = addr_b_reg;
        wlen_next       = wlen_reg;
        wprice_next     = wprice_reg;
        res_fin_next    = res_fin_reg;
        res_len_next    = res_len_reg;
        res_price_next  = res_price_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        mem_we          = 1'b0;
        mem_waddr       = clr_reg;
        mem_wdata       = '0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(MAX_NODES * MAX_NODES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (s_tuser)
                        CMD_CLEAR:
                        begin
                            clr_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        CMD_ADD:
                        begin
                            addr_a_next = AW'(in_from) * AW'(MAX_NODES) + AW'(in_to);
                            addr_b_next = AW'(in_to) * AW'(MAX_NODES) + AW'(in_from);
                            wlen_next   = WEIGHT_BITS'(s_tdata[27:12]);
                            wprice_next = WEIGHT_BITS'(s_tdata[43:28]);
                            if (!add_bad)
                            begin
                                state_next = ST_ADD_A;
                            end
                        end
                        CMD_QUERY:
                        begin
                            src_next        = NW'(in_src);
                            dst_next        = NW'(in_dst);
                            init_next       = 1'b1;
                            row_next        = NW'(in_src);
                            col_next        = '0;
                            base_len_next   = '0;
                            base_price_next = '0;
                            res_fin_next    = 1'b0;
                            res_len_next    = '0;
                            res_price_next  = '0;
                            state_next      = query_bad ? ST_DONE : ST_ISSUE;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ADD_A:
            begin
                mem_we     = 1'b1;
                mem_waddr  = addr_a_reg;
                mem_wdata  = {1'b1, wlen_reg, wprice_reg};
                state_next = ST_ADD_B;
            end
            ST_ADD_B:
            begin
                mem_we     = 1'b1;
                mem_waddr  = addr_b_reg;
                mem_wdata  = {1'b1, wlen_reg, wprice_reg};
                state_next = ST_IDLE;
            end
            ST_ISSUE:
            begin
                col_next = col_reg + NW'(1);
                if (col_reg == NW'(MAX_NODES - 1))
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (exit_pkt.valid)
                begin
                    if (exit_pkt.found)
                    begin
                        row_next        = exit_pkt.min_idx;
                        base_len_next   = exit_pkt.min_len;
                        base_price_next = exit_pkt.min_price;
                        init_next       = 1'b0;
                        col_next        = '0;
                        state_next      = ST_ISSUE;
                    end
                    else
                    begin
                        res_fin_next   = exit_pkt.dst_fin;
                        res_len_next   = exit_pkt.dst_fin ? sat_res(exit_pkt.dst_len) : '0;
                        res_price_next = exit_pkt.dst_fin ? sat_res(exit_pkt.dst_price) : '0;
                        state_next     = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, res_price_reg, res_len_reg, res_fin_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            col_reg        <= '0;
            inject_reg     <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            node_count_reg <= NODE_COUNT_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            col_reg      <= col_next;
            inject_reg   <= (state_reg == ST_ISSUE) && (col_reg == '0);
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en)
            begin
                node_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg        <= row_next;
        init_reg       <= init_next;
        base_len_reg   <= base_len_next;
        base_price_reg <= base_price_next;
        src_reg        <= src_next;
        dst_reg        <= dst_next;
        addr_a_reg     <= addr_a_next;
        addr_b_reg     <= addr_b_next;
        wlen_reg       <= wlen_next;
        wprice_reg     <= wprice_next;
        res_fin_reg    <= res_fin_next;
        res_len_reg    <= res_len_next;
        res_price_reg  <= res_price_next;
        m_tdata_reg    <= m_tdata_next;
    end

    // edge store: row = settled node, column = neighbor
    assign mem_raddr = AW'(row_reg) * AW'(MAX_NODES) + AW'(col_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= edge_t'(mem[mem_raddr]);
    end

    always_comb
    begin
        head_pkt            = '0;
        head_pkt.valid      = inject_reg;
        head_pkt.init       = init_reg;
        head_pkt.settle_idx = row_reg;
        head_pkt.src_idx    = src_reg;
        head_pkt.dst_idx    = dst_reg;
        head_pkt.base_len   = base_len_reg;
        head_pkt.base_price = base_price_reg;
    end

    assign chain[0] = head_pkt;

    // token reaches cell k in the same cycle as column k of the row
    for (genvar k = 0; k < MAX_NODES; k++)
    begin : g_cell
        spt_cell #(
            .IDX    (k),
            .LW     (LW),
            .NCW    (NCW),
            .pkt_t  (pkt_t),
            .edge_t (edge_t)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_pkt   (chain[k]),
            .edge_in  (rd_data_reg),
            .node_lim (node_lim),
            .out_pkt  (chain[k+1])
        );
    end

    assign exit_pkt = chain[MAX_NODES];

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `SPT_ASSERT_NOW(a_exit_in_wait, exit_pkt.valid, state_reg == ST_WAIT,
        "search token left the chain outside the wait state")
    `SPT_ASSERT_NOW(a_inject_after_issue, inject_reg, $past(state_reg == ST_ISSUE),
        "token injected without a row read")
    `SPT_ASSERT_NEXT(a_done_loads, (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready),
        m_tvalid_reg && (state_reg == ST_IDLE), "query result not loaded")
endmodule
`default_nettype wire

FILE: src/spt_cell.sv
// One node cell: holds a node's tentative distance and cost, relaxes it and passes the search token on.
`default_nettype none
module spt_cell #(
    parameter int  IDX = 0,
    parameter int  LW  = 22,
    parameter int  NCW = 7,
    parameter type pkt_t  = logic,
    parameter type edge_t = logic
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire pkt_t           in_pkt,
    input  wire edge_t          edge_in,
    input  wire logic [NCW-1:0] node_lim,
    output pkt_t                out_pkt
);
    logic          settled_reg, settled_next;
    logic          fin_reg, fin_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] price_reg, price_next;
    pkt_t          pkt_reg, pkt_next;

    logic          active;
    logic          is_src, is_dst, is_settle;
    logic [LW-1:0] nl, np;

    assign active    = 32'(IDX) < 32'(node_lim);
    assign is_src    = 32'(in_pkt.src_idx) == 32'(IDX);
    assign is_dst    = 32'(in_pkt.dst_idx) == 32'(IDX);
    assign is_settle = 32'(in_pkt.settle_idx) == 32'(IDX);
    assign nl        = in_pkt.base_len + LW'(edge_in.len);
    assign np        = in_pkt.base_price + LW'(edge_in.price);

    always_comb
    begin
        settled_next = settled_reg;
        fin_next     = fin_reg;
        len_next     = len_reg;
        price_next   = price_reg;
        pkt_next     = in_pkt;
        if (in_pkt.valid)
        begin
            if (in_pkt.init)
            begin
                settled_next = 1'b0;
                fin_next     = is_src;
                len_next     = '0;
                price_next   = '0;
            end
            else if (is_settle)
            begin
                settled_next = 1'b1;
            end
            else if (!settled_reg && active && edge_in.present)
            begin
                if (!fin_reg || nl < len_reg)
                begin
                    fin_next   = 1'b1;
                    len_next   = nl;
                    price_next = np;
                end
                else if (nl == len_reg && np < price_reg)
                begin
                    price_next = np;
                end
            end
            // strict compare: lowest index wins a tie
            if (active && !settled_next && fin_next &&
                (!in_pkt.found || len_next < in_pkt.min_len))
            begin
                pkt_next.found     = 1'b1;
                pkt_next.min_idx   = in_pkt.min_idx;
                pkt_next.min_idx   = $bits(in_pkt.min_idx)'(IDX);
                pkt_next.min_len   = len_next;
                pkt_next.min_price = price_next;
            end
            if (is_dst)
            begin
                pkt_next.dst_fin   = fin_next;
                pkt_next.dst_len   = len_next;
                pkt_next.dst_price = price_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settled_reg <= 1'b0;
            fin_reg     <= 1'b0;
            pkt_reg     <= '0;
        end
        else
        begin
            settled_reg <= settled_next;
            fin_reg     <= fin_next;
            pkt_reg     <= pkt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg   <= len_next;
        price_reg <= price_next;
    end

    assign out_pkt = pkt_reg;
endmodule
`default_nettype wire

FILE: bench/spt_checker.sv
// Watches the request, result and config channels, predicts each query result and compares.
`default_nettype none
module spt_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    input  wire logic [spt_pkg::IN_DATA_W-1:0] s_tdata,
    input  wire logic [spt_pkg::CMD_W-1:0]     s_tuser,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [spt_pkg::OUT_DATA_W-1:0] m_tdata,
    input  wire logic                          cfg_wr_en,
    input  wire logic [spt_pkg::CFG_W-1:0]     cfg_wr_data,
    output int                                 fail_count,
    output int                                 pending
);
    import spt_pkg::*;

    typedef struct packed {
        logic             reachable;
        logic [RES_W-1:0] path_length;
        logic [RES_W-1:0] path_price;
    } route_t;

    route_t                  route_q[$];
    bit                      link[64][64];
    logic [EDGE_FIELD_W-1:0] link_len[64][64];
    logic [EDGE_FIELD_W-1:0] link_price[64][64];
    logic [CFG_W-1:0]        node_count;

    assign pending = route_q.size();

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic longint clip(input longint v);
        return (v > longint'(RES_MAX)) ? longint'(RES_MAX) : v;
    endfunction

    // Array Dijkstra; equal distance keeps the cheaper path, lowest index settles first.
    task automatic solve_route(input int src, input int dst, output route_t r);
        int     n;
        int     v;
        bit     found;
        bit     done[64];
        bit     seen[64];
        longint best_len[64];
        longint cost[64];
        longint nl;
        longint np;
        n = (node_count == 0) ? 1 : ((node_count > 64) ? 64 : int'(node_count));
        r = '0;
        if (src >= n || dst >= n)
            return;
        for (int i = 0; i < 64; i++)
        begin
            done[i] = 0;
            seen[i] = 0;
            best_len[i] = 0;
            cost[i] = 0;
        end
        seen[src] = 1;
        while (1)
        begin
            found = 0;
            v = 0;
            for (int i = 0; i < n; i++)
                if (!done[i] && seen[i] && (!found || best_len[i] < best_len[v]))
                begin
                    found = 1;
                    v = i;
                end
            if (!found)
                break;
            done[v] = 1;
            for (int i = 0; i < n; i++)
            begin
                if (done[i] || !link[v][i])
                    continue;
                nl = best_len[v] + longint'(link_len[v][i]);
                np = cost[v] + longint'(link_price[v][i]);
                if (!seen[i] || nl < best_len[i])
                begin
                    seen[i] = 1;
                    best_len[i] = nl;
                    cost[i] = np;
                end
                else if (nl == best_len[i] && np < cost[i])
                    cost[i] = np;
            end
        end
        if (seen[dst])
        begin
            r.reachable   = 1'b1;
            r.path_length = RES_W'(clip(best_len[dst]));
            r.path_price  = RES_W'(clip(cost[dst]));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        route_t r;
        route_t want;
        int     a;
        int     b;
        if (!rst_n)
        begin
            fail_count = 0;
            node_count <= NODE_COUNT_RESET;
            for (int i = 0; i < 64; i++)
                for (int j = 0; j < 64; j++)
                    link[i][j] = 0;
        end
        else
        begin
            if (cfg_wr_en)
                node_count <= cfg_wr_data;
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == CMD_CLEAR)
                begin
                    for (int i = 0; i < 64; i++)
                        for (int j = 0; j < 64; j++)
                            link[i][j] = 0;
                end
                else if (s_tuser == CMD_ADD)
                begin
                    a = int'(s_tdata[5:0]);
                    b = int'(s_tdata[11:6]);
                    if (a != b)
                    begin
                        link[a][b] = 1;
                        link[b][a] = 1;
                        link_len[a][b] = s_tdata[27:12];
                        link_len[b][a] = s_tdata[27:12];
                        link_price[a][b] = s_tdata[43:28];
                        link_price[b][a] = s_tdata[43:28];
                    end
                end
                else if (s_tuser == CMD_QUERY)
                begin
                    solve_route(int'(s_tdata[49:44]), int'(s_tdata[55:50]), r);
                    route_q.push_back(r);
                end
            end
            if (m_tvalid && m_tready)
            begin
                if (route_q.size() == 0)
                begin
                    report("result with none expected", 1, 0);
                end
                else
                begin
                    want = route_q.pop_front();
                    if (m_tdata[0] !== want.reachable)
                        report("reachable", longint'(m_tdata[0]), longint'(want.reachable));
                    if (m_tdata[22:1] !== want.path_length)
                        report("path_length", longint'(m_tdata[22:1]),
                               longint'(want.path_length));
                    if (m_tdata[44:23] !== want.path_price)
                        report("path_price", longint'(m_tdata[44:23]),
                               longint'(want.path_price));
                    if (m_tdata[47:45] !== 3'b000)
                        report("pad bits", longint'(m_tdata[47:45]), 0);
                end
            end
        end
    end
endmodule
`default_nettype wire

FILE: bench/shortest_path_with_cost_tiebreak_tb.sv
// Testbench top: clock, reset, request stimulus, result backpressure and the verdict.
`default_nettype none
module shortest_path_with_cost_tiebreak_tb;
    import spt_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

    logic                   clk = 0;
    logic                   rst_n = 0;
    logic                   s_tvalid = 0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata = '0;
    logic [CMD_W-1:0]       s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   cfg_wr_en = 0;
    logic [CFG_W-1:0]       cfg_wr_data = '0;
    int                     fail_count;
    int                     pending;
    bit                     busy_mode;
    int                     span = 0;

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    shortest_path_with_cost_tiebreak dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    spt_checker chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .fail_count(fail_count), .pending(pending)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (busy_mode || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver stalls: mostly short, sometimes long
    always @(posedge clk)
    begin
        if (span > 0)
        begin
            span <= span - 1;
            m_tready <= 1'b0;
        end
        else if (!busy_mode && $urandom_range(0, 99) < 25)
        begin
            span <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // s_tready comes from a register, so its value between edges holds at the next edge
    task automatic send(input logic [CMD_W-1:0] cmd, input logic [IN_DATA_W-1:0] data);
        int g;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
        g = pick_gap();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    function automatic logic [IN_DATA_W-1:0] noise();
        return IN_DATA_W'({$urandom, $urandom});
    endfunction

    function automatic logic [IN_DATA_W-1:0] edge_req(int a, int b, int len, int price);
        logic [IN_DATA_W-1:0] d;
        d = noise();
        d[5:0] = 6'(a);
        d[11:6] = 6'(b);
        d[27:12] = 16'(len);
        d[43:28] = 16'(price);
        return d;
    endfunction

    function automatic logic [IN_DATA_W-1:0] route_req(int src, int dst);
        logic [IN_DATA_W-1:0] d;
        d = noise();
        d[49:44] = 6'(src);
        d[55:50] = 6'(dst);
        return d;
    endfunction

    // config only when idle: drain results, then outlast a clear or a long query
    task automatic set_nodes(input logic [CFG_W-1:0] value);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4500) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_phase(input int count, input int span_nodes);
        int hi;
        int r;
        int wl;
        int wp;
        hi = (span_nodes + 2 > 63) ? 63 : span_nodes + 2;
        busy_mode = ($urandom_range(0, 3) == 0);
        send(CMD_CLEAR, noise());
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 3) == 0)
            begin
                wl = $urandom_range(0, 65535);
                wp = $urandom_range(0, 65535);
            end
            else
            begin
                wl = $urandom_range(0, 7);
                wp = $urandom_range(0, 15);
            end
            if (r < 62)
                send(CMD_ADD, edge_req($urandom_range(0, hi), $urandom_range(0, hi), wl, wp));
            else if (r < 88)
                send(CMD_QUERY, route_req($urandom_range(0, hi), $urandom_range(0, hi)));
            else if (r < 92)
                send(CMD_UNKNOWN, noise());
            else if (r < 96)
                send(CMD_ADD, noise());
            else if (r < 98)
                send(CMD_QUERY, noise());
            else
                send(CMD_CLEAR, noise());
        end
        busy_mode = 0;
    endtask

    initial
    begin
        busy_mode = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, tie-break, replace, self-loop, unknown command
        send(CMD_ADD, edge_req(0, 63, 16'hFFFF, 16'hFFFF));
        send(CMD_QUERY, route_req(63, 0));
        send(CMD_ADD, edge_req(0, 1, 5, 9));
        send(CMD_ADD, edge_req(1, 2, 5, 1));
        send(CMD_ADD, edge_req(0, 2, 10, 20));
        send(CMD_QUERY, route_req(0, 2));
        send(CMD_ADD, edge_req(2, 0, 10, 3));
        send(CMD_QUERY, route_req(2, 0));
        send(CMD_ADD, edge_req(5, 5, 1, 1));
        send(CMD_QUERY, route_req(5, 6));
        send(CMD_QUERY, route_req(7, 7));
        send(CMD_UNKNOWN, noise());
        send(CMD_ADD, edge_req(3, 4, 0, 0));
        send(CMD_QUERY, route_req(3, 4));
        send(CMD_QUERY, route_req(62, 63));
        send(CMD_CLEAR, noise());
        send(CMD_QUERY, route_req(0, 63));
        send(CMD_ADD, edge_req(0, 40, 2, 2));
        set_nodes(7'd4);
        send(CMD_QUERY, route_req(0, 40));
        send(CMD_QUERY, route_req(3, 63));
        send(CMD_QUERY, route_req(1, 2));
        set_nodes(7'd64);
        send(CMD_QUERY, route_req(40, 0));

        set_nodes(7'd1);
        random_phase(60, 3);
        set_nodes(7'd0);
        random_phase(40, 2);
        set_nodes(7'd127);
        random_phase(150, 63);
        set_nodes(7'd8);
        random_phase(130, 8);
        set_nodes(7'($urandom_range(2, 20)));
        random_phase(130, 20);
        set_nodes(7'd64);
        random_phase(120, 63);
        set_nodes(7'd16);
        random_phase(120, 16);

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (5000) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #100000000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
`default_nettype wire
